>>> src/ebm_pkg.sv
// Shared types, codes and constants for the encoder/button menu controller.
// No dependencies; used by ebm_debounce and encoder_button_menu_controller.
package ebm_pkg;

  // Field widths fixed by the item formats
  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 16;
  localparam int VIEW_W   = 3;
  localparam int SEL_W    = 3;
  localparam int BRIGHT_W = 7;
  localparam int KIND_W   = 2;

  // Defaults and limits
  localparam int MENU_ENTRIES_DEFAULT = 5;
  localparam logic [WINDOW_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 7'd100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MIN  = 7'd5;
  localparam logic [BRIGHT_W-1:0] BRIGHT_STEP = 7'd5;
  // Highest level that can still take a full step up, lowest for a step down
  localparam logic [BRIGHT_W-1:0] BRIGHT_UP_LIMIT   = 7'd95;
  localparam logic [BRIGHT_W-1:0] BRIGHT_DOWN_LIMIT = 7'd10;
  localparam logic signed [3:0] DETENT_POS = 4'sd4;
  localparam logic signed [3:0] DETENT_NEG = -4'sd4;
  // Half of the 32-bit time circle: differences below this count as "not later"
  localparam logic [TIME_W-1:0] TIME_HALF = 32'h8000_0000;

  // Panel views
  typedef enum logic [VIEW_W-1:0] {
    V_CLOSED = 3'd0,
    V_MENU   = 3'd1,
    V_STATUS = 3'd2,
    V_INPUT  = 3'd3,
    V_BRIGHT = 3'd4,
    V_INFO   = 3'd5
  } view_t;

  // Update kinds reported with each result
  typedef enum logic [KIND_W-1:0] {
    K_NONE    = 2'd0,
    K_RENDER  = 2'd1,
    K_DISMISS = 2'd2,
    K_BRIGHT  = 2'd3
  } kind_t;

  // Input item action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic              action;
    logic              line_a;
    logic              line_b;
    logic              confirm_raw;
    logic              push_raw;
    logic              back_raw;
    logic [TIME_W-1:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   update_kind;
    logic [VIEW_W-1:0]   view_now;
    logic [SEL_W-1:0]    selected_entry;
    logic [BRIGHT_W-1:0] brightness_out;
  } out_item_t;

  // Per-button control from the top level
  typedef struct packed {
    logic sample;  // process this item's level
    logic clear;   // panel reset
  } btn_ctl_t;

  // Quadrature transition table, index {prev_ab, cur_ab}
  function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> src/encoder_button_menu_controller.sv
// Encoder and three-button menu controller, top level.
// Depends on ebm_pkg and ebm_debounce.
//
// Usage: each input item on in_valid/in_ready is one timestamped sample of the
// encoder A/B lines and the confirm, push and back buttons (or, with action
// set, a panel reset that keeps brightness). Every accepted item yields exactly
// one result item on out_valid/out_ready: the update kind and the view,
// selection and brightness after that sample.
// Each result is registered into the output queue as its item is accepted. The
// whole update is one pass of logic from the item and the state registers,
// so a new item is taken every cycle while the receiver keeps up.
// Results sit in a two-entry output queue; when the receiver stalls, one more
// item is still accepted, then in_ready drops until a result is taken.
// cfg_valid/cfg_data write the 16-bit debounce window (ms); cfg_ready is
// always high. Write it only while the block is idle.
// Reset (rst, synchronous): panel closed, selection 0, brightness 100,
// debounce window 20 ms, encoder and button trackers cleared, queue empty.
module encoder_button_menu_controller #(
  parameter int MENU_ENTRIES = ebm_pkg::MENU_ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ebm_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ebm_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ebm_pkg::WINDOW_W-1:0]  cfg_data
);
  import ebm_pkg::*;

  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(MENU_ENTRIES - 1);

  // State registers
  logic [WINDOW_W-1:0] debounce_time;
  view_t               view_reg;
  logic [SEL_W-1:0]    selection_reg;
  logic [BRIGHT_W-1:0] brightness_level;
  logic                encoder_seen;
  logic [1:0]          encoder_prev;
  logic signed [3:0]   step_accum;
  logic                activity_seen;
  logic [TIME_W-1:0]   activity_time;

  // Next values
  view_t               view_reg_next;
  logic [SEL_W-1:0]    selection_reg_next;
  logic [BRIGHT_W-1:0] brightness_level_next;
  logic                encoder_seen_next;
  logic [1:0]          encoder_prev_next;
  logic signed [3:0]   step_accum_next;
  logic                activity_seen_next;
  logic [TIME_W-1:0]   activity_time_next;
  kind_t               kind;

  // Output queue
  out_item_t q0;
  out_item_t q1;
  logic [1:0] count;
  out_item_t res;

  logic push;
  logic pop;
  logic sample_en;
  logic clear_en;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_item  = q0;
  assign sample_en = push && (in_item.action == ACT_SAMPLE);
  assign clear_en  = push && (in_item.action == ACT_CLEAR);

  // Button debouncers: confirm, push, back
  btn_ctl_t          bctl;
  logic              conf_press;
  logic              push_press;
  logic              back_press;
  logic [TIME_W-1:0] conf_ct;
  logic [TIME_W-1:0] push_ct;
  logic [TIME_W-1:0] back_ct;

  assign bctl.sample = sample_en;
  assign bctl.clear  = clear_en;

  ebm_debounce u_conf (
    .clk(clk), .rst(rst), .ctl(bctl), .level(in_item.confirm_raw),
    .now(in_item.time_now), .window(debounce_time),
    .press(conf_press), .change_time(conf_ct)
  );
  ebm_debounce u_push (
    .clk(clk), .rst(rst), .ctl(bctl), .level(in_item.push_raw),
    .now(in_item.time_now), .window(debounce_time),
    .press(push_press), .change_time(push_ct)
  );
  ebm_debounce u_back (
    .clk(clk), .rst(rst), .ctl(bctl), .level(in_item.back_raw),
    .now(in_item.time_now), .window(debounce_time),
    .press(back_press), .change_time(back_ct)
  );

  // Quadrature decode into the detent accumulator
  logic [1:0]        code;
  logic signed [3:0] acc_sum;
  logic              step_up;
  logic              step_dn;

  always_comb begin
    code               = {in_item.line_a, in_item.line_b};
    encoder_seen_next  = 1'b1;
    encoder_prev_next  = code;
    step_accum_next    = step_accum;
    activity_seen_next = activity_seen;
    activity_time_next = activity_time;
    acc_sum            = step_accum;
    step_up            = 1'b0;
    step_dn            = 1'b0;
    if (encoder_seen) begin
      if (code != encoder_prev) begin
        activity_seen_next = 1'b1;
        activity_time_next = in_item.time_now;
      end
      acc_sum = step_accum + 4'(quad_delta({encoder_prev, code}));
      if (acc_sum >= DETENT_POS) begin
        step_up         = 1'b1;
        step_accum_next = 4'sd0;
      end else if (acc_sum <= DETENT_NEG) begin
        step_dn         = 1'b1;
        step_accum_next = 4'sd0;
      end else begin
        step_accum_next = acc_sum;
      end
    end
  end

  // Quiet time and presses that started during rotation
  logic              settled;
  logic              push_motion;
  logic              back_motion;
  logic              sel;
  logic [TIME_W-1:0] quiet;
  logic [TIME_W-1:0] quiet_min;

  always_comb begin
    quiet       = in_item.time_now - activity_time_next;
    quiet_min   = {{(TIME_W-WINDOW_W-1){1'b0}}, debounce_time, 1'b0};
    settled     = !activity_seen_next || (quiet >= quiet_min);
    push_motion = activity_seen_next && ((activity_time_next - push_ct) < TIME_HALF);
    back_motion = activity_seen_next && ((activity_time_next - back_ct) < TIME_HALF);
    sel         = conf_press || (push_press && !push_motion);
  end

  // Menu and brightness update
  logic [BRIGHT_W-1:0] bright_try;

  always_comb begin
    view_reg_next         = view_reg;
    selection_reg_next    = selection_reg;
    brightness_level_next = brightness_level;
    kind                  = K_NONE;
    bright_try            = brightness_level;
    if (step_up || step_dn) begin
      if (view_reg == V_BRIGHT) begin
        if (step_up) begin
          bright_try = (brightness_level >= BRIGHT_UP_LIMIT) ? BRIGHT_MAX
                       : brightness_level + BRIGHT_STEP;
        end else begin
          bright_try = (brightness_level <= BRIGHT_DOWN_LIMIT) ? BRIGHT_MIN
                       : brightness_level - BRIGHT_STEP;
        end
        if (bright_try != brightness_level) begin
          brightness_level_next = bright_try;
          kind                  = K_BRIGHT;
        end
      end else if (view_reg == V_CLOSED || view_reg == V_MENU) begin
        view_reg_next = V_MENU;
        if (step_up) begin
          selection_reg_next = (selection_reg == SEL_LAST) ? '0 : selection_reg + 1'b1;
        end else begin
          selection_reg_next = (selection_reg == '0) ? SEL_LAST : selection_reg - 1'b1;
        end
        kind = K_RENDER;
      end
    end else if (settled) begin
      if (sel) begin
        kind = K_RENDER;
        if (view_reg != V_MENU) begin
          view_reg_next = V_MENU;
        end else begin
          case (selection_reg)
            3'd0: begin
              view_reg_next = V_CLOSED;
              kind          = K_DISMISS;
            end
            3'd1:    view_reg_next = V_STATUS;
            3'd2:    view_reg_next = V_INPUT;
            3'd3:    view_reg_next = V_BRIGHT;
            default: view_reg_next = V_INFO;
          endcase
        end
      end else if (back_press && !back_motion) begin
        if (view_reg == V_MENU) begin
          view_reg_next = V_CLOSED;
          kind          = K_DISMISS;
        end else if (view_reg != V_CLOSED) begin
          view_reg_next = V_MENU;
          kind          = K_RENDER;
        end
      end
    end
  end

  // Result item for the accepted sample
  always_comb begin
    if (in_item.action == ACT_CLEAR) begin
      res.update_kind    = K_NONE;
      res.view_now       = V_CLOSED;
      res.selected_entry = '0;
    end else begin
      res.update_kind    = kind;
      res.view_now       = view_reg_next;
      res.selected_entry = selection_reg_next;
    end
    res.brightness_out = (in_item.action == ACT_CLEAR) ? brightness_level
                         : brightness_level_next;
  end

  // Panel state
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time    <= DEBOUNCE_RESET;
      brightness_level <= BRIGHT_MAX;
    end else begin
      if (cfg_valid && cfg_ready) begin
        debounce_time <= cfg_data;
      end
      if (sample_en) begin
        brightness_level <= brightness_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      view_reg      <= V_CLOSED;
      selection_reg <= '0;
      encoder_seen  <= 1'b0;
      encoder_prev  <= 2'd0;
      step_accum    <= 4'sd0;
      activity_seen <= 1'b0;
      activity_time <= '0;
    end else if (sample_en) begin
      view_reg      <= view_reg_next;
      selection_reg <= selection_reg_next;
      encoder_seen  <= encoder_seen_next;
      encoder_prev  <= encoder_prev_next;
      step_accum    <= step_accum_next;
      activity_seen <= activity_seen_next;
      activity_time <= activity_time_next;
    end
  end

  // Two-entry result queue, head in q0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        q0 <= q1;
      end else if (push) begin
        q0 <= res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue overflow");

  a_accum_range: assert property (@(posedge clk) disable iff (rst)
    (step_accum > DETENT_NEG) && (step_accum < DETENT_POS))
    else $error("detent accumulator out of range");

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    selection_reg <= SEL_LAST)
    else $error("selection beyond menu");

  a_bright_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.brightness_out >= BRIGHT_MIN &&
                   out_item.brightness_out <= BRIGHT_MAX))
    else $error("brightness out of range");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear_en |=> (view_reg == V_CLOSED && !encoder_seen && !activity_seen))
    else $error("panel reset did not clear state");

endmodule

>>> src/ebm_debounce.sv
// Debouncer for one button: tracks raw level, stable level and change time.
// Depends on ebm_pkg for widths and the control struct.
module ebm_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  ebm_pkg::btn_ctl_t             ctl,
  input  logic                          level,
  input  logic [ebm_pkg::TIME_W-1:0]    now,
  input  logic [ebm_pkg::WINDOW_W-1:0]  window,
  output logic                          press,
  output logic [ebm_pkg::TIME_W-1:0]    change_time
);
  import ebm_pkg::*;

  logic              raw;
  logic              stable;
  logic [TIME_W-1:0] ct;
  logic [TIME_W-1:0] ct_next;
  logic [TIME_W-1:0] elapsed;
  logic              settle;

  // New raw edge restarts the window
  always_comb begin
    ct_next = (level != raw) ? now : ct;
    elapsed = now - ct_next;
    settle  = (stable != level) && (elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window});
    press   = settle && level;
    change_time = ct_next;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      raw    <= 1'b0;
      stable <= 1'b0;
      ct     <= '0;
    end else if (ctl.sample) begin
      raw <= level;
      ct  <= ct_next;
      if (settle) begin
        stable <= level;
      end
    end
  end

endmodule

>>> dv/tb_encoder_button_menu_controller.sv
`timescale 1ns / 1ps
// Testbench for encoder_button_menu_controller: directed and random encoder/button
// samples checked against an in-bench panel predictor. Depends on ebm_pkg and the RTL.
module tb_encoder_button_menu_controller;
  import ebm_pkg::*;

  localparam int MENU_N = MENU_ENTRIES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BTN_CONFIRM = 0;
  localparam int BTN_PUSH = 1;
  localparam int BTN_BACK = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WINDOW_W-1:0] cfg_data = '0;

  encoder_button_menu_controller #(.MENU_ENTRIES(MENU_N)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Panel predictor state
  logic [WINDOW_W-1:0] window_ms;
  view_t               pan_view;
  int                  pan_sel;
  logic [BRIGHT_W-1:0] pan_bright;
  bit                  enc_seen;
  logic [1:0]          enc_prev;
  int                  enc_accum;
  bit                  motion_seen;
  logic [TIME_W-1:0]   motion_time;
  bit                  btn_level[3];
  bit                  btn_stable[3];
  logic [TIME_W-1:0]   btn_since[3];

  // Quadrature delta, index {previous AB, current AB}
  int quad_delta_tbl[16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

  out_item_t expected_panel_q[$];
  int mismatch_count = 0;
  int sent_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Stimulus side: current time, encoder position on the Gray cycle, button levels
  logic [TIME_W-1:0] cur_time = '0;
  int enc_pos = 0;
  logic [1:0] gray_seq[4] = '{2'b00, 2'b10, 2'b11, 2'b01};
  bit btn_drive[3] = '{0, 0, 0};

  // Everything but brightness and the window back to reset
  function automatic void clear_panel();
    pan_view = V_CLOSED;
    pan_sel = 0;
    enc_seen = 0;
    enc_prev = 2'b00;
    enc_accum = 0;
    motion_seen = 0;
    motion_time = '0;
    for (int i = 0; i < 3; i++) begin
      btn_level[i] = 0;
      btn_stable[i] = 0;
      btn_since[i] = '0;
    end
  endfunction

  // Returns 1 on a debounced press edge of button i
  function automatic bit debounce_edge(int i, bit level, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held;
    if (level != btn_level[i]) begin
      btn_level[i] = level;
      btn_since[i] = now;
    end
    held = now - btn_since[i];
    if (btn_stable[i] == btn_level[i] || held < {16'd0, window_ms}) return 1'b0;
    btn_stable[i] = btn_level[i];
    return btn_stable[i];
  endfunction

  // Raw change of button i no later than the last encoder activity
  function automatic bit began_while_turning(int i);
    logic [TIME_W-1:0] lag;
    lag = motion_time - btn_since[i];
    return motion_seen && (lag < TIME_HALF);
  endfunction

  function automatic out_item_t predict_panel(in_item_t it);
    logic [1:0] code;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] quiet_for;
    int step;
    int nxt;
    bit conf, push, back, settled, push_mot, back_mot, sel_hit;
    kind_t kind;
    out_item_t r;
    kind = K_NONE;
    if (it.action == ACT_CLEAR) begin
      clear_panel();
    end else begin
      now = it.time_now;
      code = {it.line_a, it.line_b};
      step = 0;
      // Encoder decode: first sample only latches
      if (!enc_seen) begin
        enc_seen = 1;
        enc_prev = code;
      end else begin
        if (code != enc_prev) begin
          motion_seen = 1;
          motion_time = now;
        end
        enc_accum += quad_delta_tbl[{enc_prev, code}];
        enc_prev = code;
        if (enc_accum >= int'(DETENT_POS)) begin
          enc_accum = 0;
          step = 1;
        end else if (enc_accum <= int'(DETENT_NEG)) begin
          enc_accum = 0;
          step = -1;
        end
      end
      conf = debounce_edge(BTN_CONFIRM, it.confirm_raw, now);
      push = debounce_edge(BTN_PUSH, it.push_raw, now);
      back = debounce_edge(BTN_BACK, it.back_raw, now);
      quiet_for = now - motion_time;
      settled = !motion_seen || (quiet_for >= ({16'd0, window_ms} << 1));
      push_mot = began_while_turning(BTN_PUSH);
      back_mot = began_while_turning(BTN_BACK);
      sel_hit = conf || (push && !push_mot);

      if (step != 0) begin
        if (pan_view == V_BRIGHT) begin
          nxt = int'(pan_bright) + step * int'(BRIGHT_STEP);
          if (nxt < int'(BRIGHT_MIN)) nxt = int'(BRIGHT_MIN);
          if (nxt > int'(BRIGHT_MAX)) nxt = int'(BRIGHT_MAX);
          if (nxt != int'(pan_bright)) begin
            pan_bright = nxt[BRIGHT_W-1:0];
            kind = K_BRIGHT;
          end
        end else if (pan_view == V_CLOSED || pan_view == V_MENU) begin
          pan_view = V_MENU;
          if (step > 0) pan_sel = (pan_sel + 1) % MENU_N;
          else pan_sel = (pan_sel + MENU_N - 1) % MENU_N;
          kind = K_RENDER;
        end
      end else if (settled) begin
        if (sel_hit) begin
          kind = K_RENDER;
          if (pan_view != V_MENU) begin
            pan_view = V_MENU;
          end else begin
            // Menu entry index picks the view; entry 0 closes
            case (pan_sel)
              0: begin
                pan_view = V_CLOSED;
                kind = K_DISMISS;
              end
              1: pan_view = V_STATUS;
              2: pan_view = V_INPUT;
              3: pan_view = V_BRIGHT;
              default: pan_view = V_INFO;
            endcase
          end
        end else if (back && !back_mot) begin
          if (pan_view == V_MENU) begin
            pan_view = V_CLOSED;
            kind = K_DISMISS;
          end else if (pan_view != V_CLOSED) begin
            pan_view = V_MENU;
            kind = K_RENDER;
          end
        end
      end
    end
    r.update_kind = kind;
    r.view_now = pan_view;
    r.selected_entry = pan_sel[SEL_W-1:0];
    r.brightness_out = pan_bright;
    return r;
  endfunction

  // Receiver side stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  // Cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_panel_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing expected: kind %0d view %0d sel %0d bright %0d",
                   $realtime, out_item.update_kind, out_item.view_now,
                   out_item.selected_entry, out_item.brightness_out);
        mismatch_count++;
      end else begin
        want = expected_panel_q.pop_front();
        if (out_item.update_kind !== want.update_kind || out_item.view_now !== want.view_now ||
            out_item.selected_entry !== want.selected_entry ||
            out_item.brightness_out !== want.brightness_out) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch kind %0d/%0d view %0d/%0d sel %0d/%0d bright %0d/%0d (exp/got)",
                     $realtime, want.update_kind, out_item.update_kind, want.view_now,
                     out_item.view_now, want.selected_entry, out_item.selected_entry,
                     want.brightness_out, out_item.brightness_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_encoder_button_menu_controller: errors");
    $finish;
  end

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_panel_q.push_back(predict_panel(it));
    sent_count++;
  endtask

  // Sample of the current levels, dt ms after the previous one
  task automatic send_sample(input logic [TIME_W-1:0] dt);
    in_item_t it;
    cur_time = cur_time + dt;
    it.action = ACT_SAMPLE;
    {it.line_a, it.line_b} = gray_seq[enc_pos];
    it.confirm_raw = btn_drive[BTN_CONFIRM];
    it.push_raw = btn_drive[BTN_PUSH];
    it.back_raw = btn_drive[BTN_BACK];
    it.time_now = cur_time;
    send_item(it);
  endtask

  // Panel reset with random content in the ignored fields
  task automatic send_clear();
    in_item_t it;
    it.action = ACT_CLEAR;
    it.line_a = 1'($urandom_range(1));
    it.line_b = 1'($urandom_range(1));
    it.confirm_raw = 1'($urandom_range(1));
    it.push_raw = 1'($urandom_range(1));
    it.back_raw = 1'($urandom_range(1));
    it.time_now = $urandom();
    send_item(it);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_panel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] v);
    hold_until_drained();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_ms = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] time_unit();
    return {16'd0, window_ms} / 4 + 1;
  endfunction

  // Quarter steps along the Gray cycle; +1 counts up, -1 down
  task automatic step_encoder(input int dir, input int quarters);
    for (int q = 0; q < quarters; q++) begin
      enc_pos = (enc_pos + 4 + dir) % 4;
      send_sample($urandom_range(1, 3));
    end
  endtask

  // Clean press after a quiet spell, held past the window, then released
  task automatic press_button(input int which);
    logic [TIME_W-1:0] w;
    w = {16'd0, window_ms};
    btn_drive[which] = 1;
    send_sample(2 * w + $urandom_range(1, time_unit()));
    send_sample(w + $urandom_range(0, time_unit()));
    btn_drive[which] = 0;
    send_sample($urandom_range(1, time_unit()));
    send_sample(w + $urandom_range(0, time_unit()));
  endtask

  task automatic test_first_sample();
    enc_pos = 2;
    send_sample(0);
  endtask

  task automatic test_rotation();
    step_encoder(1, 4);
    step_encoder(-1, 4);
  endtask

  task automatic test_select_and_back();
    press_button(BTN_CONFIRM);
    press_button(BTN_BACK);
  endtask

  // Push that goes down while the knob turns is dropped
  task automatic test_push_in_motion();
    btn_drive[BTN_PUSH] = 1;
    step_encoder(1, 4);
    send_sample(2 * {16'd0, window_ms} + time_unit());
    btn_drive[BTN_PUSH] = 0;
    send_sample({16'd0, window_ms});
  endtask

  task automatic test_panel_clear();
    send_clear();
  endtask

  // Time stamps across the 2^32 wrap
  task automatic test_time_wrap();
    cur_time = 32'hFFFF_FFFE;
    send_sample(1);
    step_encoder(-1, 4);
  endtask

  // Open the brightness view and run into both clamps
  task automatic test_brightness_limits();
    write_window(DEBOUNCE_RESET);
    send_clear();
    send_sample(1);
    step_encoder(1, 12);
    press_button(BTN_CONFIRM);
    step_encoder(-1, 80);
    step_encoder(1, 80);
    press_button(BTN_BACK);
  endtask

  task automatic test_random(input int n, input int idle_in, input int stall_out,
                             input logic [WINDOW_W-1:0] win);
    int start;
    int pick;
    int q;
    bit paused;
    paused = 0;
    write_window(win);
    send_idle_pct = idle_in;
    recv_stall_pct = stall_out;
    start = sent_count;
    while (sent_count - start < n) begin
      // Let everything drain once mid-phase
      if (!paused && sent_count - start >= n / 2) begin
        paused = 1;
        hold_until_drained();
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        step_encoder($urandom_range(1) ? 1 : -1, 4 * $urandom_range(1, 3));
      end else if (pick < 60) begin
        press_button($urandom_range(2));
      end else if (pick < 67) begin
        // Half turn that backs out
        q = $urandom_range(1, 3);
        step_encoder(1, q);
        step_encoder(-1, q);
      end else if (pick < 73) begin
        // Bounce shorter than the window
        q = $urandom_range(2);
        btn_drive[q] = 1;
        send_sample(2 * {16'd0, window_ms} + 1);
        btn_drive[q] = 0;
        send_sample($urandom_range(0, {16'd0, window_ms} / 2));
      end else if (pick < 78) begin
        send_clear();
      end else begin
        enc_pos = $urandom_range(3);
        for (int i = 0; i < 3; i++) btn_drive[i] = 1'($urandom_range(1));
        case ($urandom_range(2))
          0: send_sample($urandom_range(0, 3));
          1: send_sample($urandom_range(0, 3 * time_unit()));
          default: begin
            cur_time = $urandom();
            send_sample(0);
          end
        endcase
      end
    end
  endtask

  initial begin
    window_ms = DEBOUNCE_RESET;
    pan_bright = BRIGHT_MAX;
    clear_panel();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_sample();
    test_rotation();
    test_select_and_back();
    test_push_in_motion();
    test_panel_clear();
    test_time_wrap();
    test_brightness_limits();
    test_random(80, 0, 0, 16'd7);
    test_random(100, 71, 0, 16'd0);
    test_random(90, 0, 71, 16'hFFFF);
    test_random(100, 36, 36, 16'($urandom_range(1, 300)));

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_panel_q.size() == 0)
      $display("tb_encoder_button_menu_controller: clean");
    else
      $display("tb_encoder_button_menu_controller: errors");
    $finish;
  end

endmodule
